[design/midpoint_ellipse_point_generator_core_defines.svh]
// Assertion macros shared by the ellipse point generator.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef MIDPOINT_ELLIPSE_POINT_GENERATOR_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_POINT_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEPG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mepg_pkg.sv]
package mepg_pkg;

    // Radius width; every internal width of the datapath follows from it.
    localparam int RADIUS_BITS = 10;
    // Squared radius.
    localparam int SQ_BITS = 2 * RADIUS_BITS;
    // Slope terms 2*ry^2*x and 2*rx^2*y.
    localparam int STEP_BITS = SQ_BITS + RADIUS_BITS + 4;
    // Decision value, held scaled by four, two's complement.
    localparam int DEC_BITS = 2 * SQ_BITS + 8;
    // Precomputed sums of up to five squared radii.
    localparam int CONST_BITS = SQ_BITS + 3;
    // Shared multiplier operand and product widths.
    localparam int MUL_BITS = SQ_BITS + 2;
    localparam int PROD_BITS = 2 * MUL_BITS;

    // Screen coordinates.
    localparam int COORD_BITS = 10;
    localparam int POINT_BITS = 12;
    localparam logic [COORD_BITS-1:0] CENTER_RESET = 10'd200;

    // Configuration register indexes.
    localparam int REG_INDEX_BITS = 1;
    localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_X = 1'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_Y = 1'd1;

    // Command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

endpackage

[design/mepg_in_if.sv]
// Command channel: a start with radii, or a request for the next point.
interface mepg_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [mepg_pkg::RADIUS_BITS-1:0] radius_x;
    logic [mepg_pkg::RADIUS_BITS-1:0] radius_y;

    modport source (output valid, cmd, radius_x, radius_y, input ready);
    modport sink (input valid, cmd, radius_x, radius_y, output ready);
endinterface

[design/mepg_out_if.sv]
// Point channel: four mirrored screen coordinates and an end flag.
interface mepg_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mepg_pkg::POINT_BITS-1:0] x_right;
    logic signed [mepg_pkg::POINT_BITS-1:0] x_left;
    logic signed [mepg_pkg::POINT_BITS-1:0] y_below;
    logic signed [mepg_pkg::POINT_BITS-1:0] y_above;
    logic                                   last_point;

    modport source (output valid, x_right, x_left, y_below, y_above, last_point, input ready);
    modport sink (input valid, x_right, x_left, y_below, y_above, last_point, output ready);
endinterface

[design/midpoint_ellipse_point_generator_core.sv]
// Two-region midpoint ellipse rasterizer with a pull interface. A start item
// (cmd 0) loads the radii and produces no point; it occupies the block through
// states ST0 to ST3, spent on three products through the single shared
// multiplier. Each next item (cmd 1) waits for a free output register, produces
// the current first-quadrant point mirrored around the configured center, flagged
// last for the point on the x axis, and then advances the point, with additions
// alone while it stays in a region; no new item is accepted before it is done.
// The one item that crosses from region 1 to region 2 runs on through states
// R2A to R2G, since the new decision value needs five more products through the
// same multiplier. A next item with no ellipse running produces nothing. The
// center registers reset to 200 and may be written only while the block is idle.
`include "midpoint_ellipse_point_generator_core_defines.svh"

module midpoint_ellipse_point_generator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [mepg_pkg::REG_INDEX_BITS-1:0] reg_index,
    input  logic [mepg_pkg::COORD_BITS-1:0]     write_data,
    mepg_in_if.sink                             command,
    mepg_out_if.source                          point
);

    localparam int RB = mepg_pkg::RADIUS_BITS;
    localparam int SQ = mepg_pkg::SQ_BITS;
    localparam int SW = mepg_pkg::STEP_BITS;
    localparam int DW = mepg_pkg::DEC_BITS;
    localparam int KW = mepg_pkg::CONST_BITS;
    localparam int MW = mepg_pkg::MUL_BITS;
    localparam int PW = mepg_pkg::PROD_BITS;
    localparam int CW = mepg_pkg::COORD_BITS;
    localparam int OW = mepg_pkg::POINT_BITS;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EMIT = 4'd1;
    localparam logic [3:0] S_ST0  = 4'd2;
    localparam logic [3:0] S_ST1  = 4'd3;
    localparam logic [3:0] S_ST2  = 4'd4;
    localparam logic [3:0] S_ST3  = 4'd5;
    localparam logic [3:0] S_R2A  = 4'd6;
    localparam logic [3:0] S_R2B  = 4'd7;
    localparam logic [3:0] S_R2C  = 4'd8;
    localparam logic [3:0] S_R2D  = 4'd9;
    localparam logic [3:0] S_R2E  = 4'd10;
    localparam logic [3:0] S_R2F  = 4'd11;
    localparam logic [3:0] S_R2G  = 4'd12;

    // Ellipse phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           phase_reg, phase_next;
    logic [CW-1:0]        center_x_reg, center_y_reg;
    logic [RB-1:0]        rad_x_reg, rad_x_next;
    logic [RB-1:0]        rad_y_reg, rad_y_next;
    logic [SQ-1:0]        rx2_reg, rx2_next;
    logic [SQ-1:0]        ry2_reg, ry2_next;
    logic [KW-1:0]        r1_neg_k_reg, r1_neg_k_next;
    logic [KW-1:0]        r1_pos_k_reg, r1_pos_k_next;
    logic [KW-1:0]        r2_pos_k_reg, r2_pos_k_next;
    logic [KW-1:0]        r2_neg_k_reg, r2_neg_k_next;
    logic [RB-1:0]        offset_x_reg, offset_x_next;
    logic [RB-1:0]        offset_y_reg, offset_y_next;
    logic [SW-1:0]        step_x_reg, step_x_next;
    logic [SW-1:0]        step_y_reg, step_y_next;
    logic signed [DW-1:0] dec_reg, dec_next;
    logic [PW-1:0]        prod_reg;
    logic [MW-1:0]        mul_a, mul_b;

    logic                 out_valid_reg, out_valid_next;
    logic signed [OW-1:0] x_right_reg, x_left_reg, y_below_reg, y_above_reg;
    logic                 last_reg;
    logic                 load_out;
    logic                 last_next;
    logic                 out_free;

    logic [SW-1:0]        step_x_inc, step_y_dec;
    logic                 dec_neg, dec_pos, step_less, use_r1;
    logic signed [DW-1:0] sx, sy, step_term, dec_step, dec_start, prod_x4;
    logic [KW-1:0]        rx2_k, ry2_k;

    // Handshake and output port drive.
    assign command.ready    = (state_reg == S_IDLE);
    assign point.valid      = out_valid_reg;
    assign point.x_right    = x_right_reg;
    assign point.x_left     = x_left_reg;
    assign point.y_below    = y_below_reg;
    assign point.y_above    = y_above_reg;
    assign point.last_point = last_reg;
    assign out_free         = !out_valid_reg || point.ready;

    // Incremental slope updates and decision sign.
    assign step_x_inc = step_x_reg + (SW'(ry2_reg) << 1);
    assign step_y_dec = step_y_reg - (SW'(rx2_reg) << 1);
    assign dec_neg    = dec_reg[DW-1];
    assign dec_pos    = !dec_neg && (dec_reg != '0);
    assign step_less  = (step_x_reg < step_y_reg);
    assign sx         = signed'(DW'(step_x_reg));
    assign sy         = signed'(DW'(step_y_reg));

    // Decision increment over four; the region constants fold in the step sizes.
    assign use_r1 = (state_reg == S_EMIT) && (phase_reg == PH_R1);
    always_comb
    begin
        if (use_r1)
        begin
            step_term = dec_neg ? (sx + signed'(DW'(r1_neg_k_reg)))
                                : (sx - sy + signed'(DW'(r1_pos_k_reg)));
        end
        else
        begin
            step_term = dec_pos ? (signed'(DW'(r2_pos_k_reg)) - sy)
                                : (sx - sy + signed'(DW'(r2_neg_k_reg)));
        end
    end
    assign dec_step = dec_reg + (step_term <<< 2);

    // Start decision 4*ry^2 - 4*rx^2*ry + rx^2; the product holds rx^2*ry here.
    assign prod_x4   = signed'(DW'(prod_reg) << 2);
    assign dec_start = signed'(DW'(ry2_reg) << 2) - prod_x4 + signed'(DW'(rx2_reg));
    assign rx2_k     = KW'(rx2_reg);
    assign ry2_k     = KW'(ry2_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            S_ST0:
            begin
                mul_a = MW'(rad_x_reg);
                mul_b = MW'(rad_x_reg);
            end
            S_ST1:
            begin
                mul_a = MW'(rad_y_reg);
                mul_b = MW'(rad_y_reg);
            end
            S_ST2:
            begin
                mul_a = MW'(rx2_reg);
                mul_b = MW'(rad_y_reg);
            end
            S_R2A:
            begin
                mul_a = MW'({offset_x_reg, 1'b1});
                mul_b = MW'({offset_x_reg, 1'b1});
            end
            S_R2B:
            begin
                mul_a = MW'(ry2_reg);
                mul_b = prod_reg[MW-1:0];
            end
            S_R2C:
            begin
                mul_a = MW'(offset_y_reg - RB'(1));
                mul_b = MW'(offset_y_reg - RB'(1));
            end
            S_R2D:
            begin
                mul_a = MW'(rx2_reg);
                mul_b = MW'(prod_reg[SQ-1:0]);
            end
            S_R2E:
            begin
                mul_a = MW'(rx2_reg);
                mul_b = MW'(ry2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        rad_x_next    = rad_x_reg;
        rad_y_next    = rad_y_reg;
        rx2_next      = rx2_reg;
        ry2_next      = ry2_reg;
        r1_neg_k_next = r1_neg_k_reg;
        r1_pos_k_next = r1_pos_k_reg;
        r2_pos_k_next = r2_pos_k_reg;
        r2_neg_k_next = r2_neg_k_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        dec_next      = dec_reg;
        load_out      = 1'b0;
        last_next     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (command.valid)
                begin
                    if (command.cmd == mepg_pkg::CMD_START)
                    begin
                        rad_x_next = command.radius_x;
                        rad_y_next = command.radius_y;
                        state_next = S_ST0;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (phase_reg == PH_R1 && step_less)
                    begin
                        // Region 1 step: x always advances, y on a non-negative decision.
                        offset_x_next = offset_x_reg + RB'(1);
                        step_x_next   = step_x_inc;
                        if (!dec_neg)
                        begin
                            offset_y_next = offset_y_reg - RB'(1);
                            step_y_next   = step_y_dec;
                        end
                        dec_next = dec_step;
                    end
                    else if (offset_y_reg == '0)
                    begin
                        // Point on the x axis ends the ellipse.
                        last_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (phase_reg == PH_R1)
                    begin
                        state_next = S_R2A;
                    end
                    else
                    begin
                        // Region 2 step: y always falls, x on a non-positive decision.
                        offset_y_next = offset_y_reg - RB'(1);
                        step_y_next   = step_y_dec;
                        if (!dec_pos)
                        begin
                            offset_x_next = offset_x_reg + RB'(1);
                            step_x_next   = step_x_inc;
                        end
                        dec_next = dec_step;
                    end
                end
            end
            S_ST0:
            begin
                state_next = S_ST1;
            end
            S_ST1:
            begin
                rx2_next   = prod_reg[SQ-1:0];
                state_next = S_ST2;
            end
            S_ST2:
            begin
                ry2_next   = prod_reg[SQ-1:0];
                state_next = S_ST3;
            end
            S_ST3:
            begin
                // Initial point (0, ry) and the folded step constants.
                offset_x_next = '0;
                offset_y_next = rad_y_reg;
                step_x_next   = '0;
                step_y_next   = SW'(prod_reg) << 1;
                dec_next      = dec_start;
                r1_neg_k_next = (ry2_k << 1) + ry2_k;
                r1_pos_k_next = (ry2_k << 1) + ry2_k + (rx2_k << 1);
                r2_pos_k_next = (rx2_k << 1) + rx2_k;
                r2_neg_k_next = (ry2_k << 1) + (rx2_k << 1) + rx2_k;
                phase_next    = PH_R1;
                state_next    = S_IDLE;
            end
            S_R2A:
            begin
                state_next = S_R2B;
            end
            S_R2B:
            begin
                state_next = S_R2C;
            end
            S_R2C:
            begin
                // ry^2 * (2x+1)^2
                dec_next   = signed'(DW'(prod_reg));
                state_next = S_R2D;
            end
            S_R2D:
            begin
                state_next = S_R2E;
            end
            S_R2E:
            begin
                // plus 4 * rx^2 * (y-1)^2
                dec_next   = dec_reg + prod_x4;
                state_next = S_R2F;
            end
            S_R2F:
            begin
                // minus 4 * rx^2 * ry^2
                dec_next   = dec_reg - prod_x4;
                state_next = S_R2G;
            end
            S_R2G:
            begin
                // First region 2 step from the fresh decision value.
                offset_y_next = offset_y_reg - RB'(1);
                step_y_next   = step_y_dec;
                if (!dec_pos)
                begin
                    offset_x_next = offset_x_reg + RB'(1);
                    step_x_next   = step_x_inc;
                end
                dec_next   = dec_step;
                phase_next = PH_R2;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy.
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (point.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            center_x_reg  <= mepg_pkg::CENTER_RESET;
            center_y_reg  <= mepg_pkg::CENTER_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (write_enable)
            begin
                case (reg_index)
                    mepg_pkg::REG_CENTER_X: center_x_reg <= write_data;
                    mepg_pkg::REG_CENTER_Y: center_y_reg <= write_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers; only meaningful once a start has run.
    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        rad_x_reg    <= rad_x_next;
        rad_y_reg    <= rad_y_next;
        rx2_reg      <= rx2_next;
        ry2_reg      <= ry2_next;
        r1_neg_k_reg <= r1_neg_k_next;
        r1_pos_k_reg <= r1_pos_k_next;
        r2_pos_k_reg <= r2_pos_k_next;
        r2_neg_k_reg <= r2_neg_k_next;
        offset_x_reg <= offset_x_next;
        offset_y_reg <= offset_y_next;
        step_x_reg   <= step_x_next;
        step_y_reg   <= step_y_next;
        dec_reg      <= dec_next;
        if (load_out)
        begin
            x_right_reg <= signed'(OW'(center_x_reg) + OW'(offset_x_reg));
            x_left_reg  <= signed'(OW'(center_x_reg) - OW'(offset_x_reg));
            y_below_reg <= signed'(OW'(center_y_reg) + OW'(offset_y_reg));
            y_above_reg <= signed'(OW'(center_y_reg) - OW'(offset_y_reg));
            last_reg    <= last_next;
        end
    end

    // A new point only ever comes out of the emit state.
    `MEPG_ASSERT_SAME(a_point_from_emit, $rose(point.valid), $past(state_reg) == S_EMIT, "point without emit")
    // The last point closes the ellipse.
    `MEPG_ASSERT_NEXT(a_last_closes, load_out && last_next, phase_reg == PH_IDLE, "ellipse still open after last point")
    // A start always lands at the top of the ellipse in region 1.
    `MEPG_ASSERT_NEXT(a_start_to_r1, state_reg == S_ST3, phase_reg == PH_R1 && offset_x_reg == '0, "start did not enter region 1")
    // In region 1 the y slope term is zero once y has reached zero.
    `MEPG_ASSERT_SAME(a_r1_axis, phase_reg == PH_R1 && offset_y_reg == '0, step_y_reg == '0, "slope term out of step with y")

endmodule

[tb/midpoint_ellipse_point_generator_core_test.sv]
`timescale 1ns / 100ps

module midpoint_ellipse_point_generator_core_test;

    localparam int RADIUS_BITS = mepg_pkg::RADIUS_BITS;
    localparam int COORD_BITS = mepg_pkg::COORD_BITS;
    localparam int POINT_BITS = mepg_pkg::POINT_BITS;
    localparam int REG_INDEX_BITS = mepg_pkg::REG_INDEX_BITS;

    localparam int CYCLE_LIMIT = 500000;
    // Longest internal job is the region crossing, longer than a start.
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic signed [POINT_BITS-1:0] x_right;
        logic signed [POINT_BITS-1:0] x_left;
        logic signed [POINT_BITS-1:0] y_below;
        logic signed [POINT_BITS-1:0] y_above;
        logic                         last_point;
    } point_t;

    typedef enum logic [1:0] {
        TRACE_IDLE,
        TRACE_REGION1,
        TRACE_REGION2
    } trace_phase_t;

    logic clk;
    logic rst_n;
    logic write_enable;
    logic [REG_INDEX_BITS-1:0] reg_index;
    logic [COORD_BITS-1:0] write_data;

    mepg_in_if  cmd_if ();
    mepg_out_if pt_if ();

    midpoint_ellipse_point_generator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .command      (cmd_if),
        .point        (pt_if)
    );

    // Shadow of the center registers and of the rasterizer state.
    logic [COORD_BITS-1:0] center_x_shadow = mepg_pkg::CENTER_RESET;
    logic [COORD_BITS-1:0] center_y_shadow = mepg_pkg::CENTER_RESET;
    trace_phase_t trace_phase = TRACE_IDLE;
    bit [63:0] cur_x = '0;
    bit [63:0] cur_y = '0;
    bit [63:0] decision4 = '0;
    bit [63:0] slope_x = '0;
    bit [63:0] slope_y = '0;
    bit [63:0] rx_sq = '0;
    bit [63:0] ry_sq = '0;

    point_t pending_points[$];

    int errors = 0;
    int cycle_count = 0;
    int items_counted = 0;
    int starts_sent = 0;
    int ellipses_abandoned = 0;
    int points_checked = 0;
    int center_settings = 1;
    int burst_left = 0;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int stall_mode_left = 0;
    int stall_hold = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Advances the ellipse trace by one command and returns 1 when a point results.
    function automatic bit trace_point(input logic cmd, input logic [RADIUS_BITS-1:0] rx,
                                       input logic [RADIUS_BITS-1:0] ry, output point_t pt);
        bit [63:0] rx64;
        bit [63:0] ry64;
        bit [63:0] tx;
        bit [63:0] ty;
        bit [63:0] sum;
        bit        was_negative;
        bit        is_positive;
        pt = '0;
        rx64 = 64'(rx);
        ry64 = 64'(ry);
        if (cmd == mepg_pkg::CMD_START)
        begin
            rx_sq = rx64 * rx64;
            ry_sq = ry64 * ry64;
            cur_x = '0;
            cur_y = ry64;
            slope_x = '0;
            slope_y = 2 * rx_sq * ry64;
            decision4 = 4 * ry_sq - 4 * rx_sq * ry64 + rx_sq;
            trace_phase = TRACE_REGION1;
            return 1'b0;
        end
        if (trace_phase == TRACE_IDLE)
        begin
            return 1'b0;
        end

        // Mirror the current quadrant point around the center.
        sum = center_x_shadow + cur_x;
        pt.x_right = sum[POINT_BITS-1:0];
        sum = center_x_shadow - cur_x;
        pt.x_left = sum[POINT_BITS-1:0];
        sum = center_y_shadow + cur_y;
        pt.y_below = sum[POINT_BITS-1:0];
        sum = center_y_shadow - cur_y;
        pt.y_above = sum[POINT_BITS-1:0];

        // Region 1 steps x while the slope is shallow.
        if (trace_phase == TRACE_REGION1)
        begin
            if (slope_x < slope_y)
            begin
                was_negative = decision4[63];
                cur_x += 1;
                slope_x += 2 * ry_sq;
                if (was_negative)
                begin
                    decision4 += 4 * (slope_x + ry_sq);
                end
                else
                begin
                    cur_y -= 1;
                    slope_y -= 2 * rx_sq;
                    decision4 += 4 * (slope_x - slope_y + ry_sq);
                end
                pt.last_point = 1'b0;
                return 1'b1;
            end
            tx = 2 * cur_x + 1;
            ty = (cur_y != 0) ? cur_y - 1 : 64'd1;
            decision4 = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
            trace_phase = TRACE_REGION2;
        end

        // Region 2 steps y down to the x axis.
        if (cur_y > 0)
        begin
            is_positive = !decision4[63] && (decision4 != 0);
            cur_y -= 1;
            slope_y -= 2 * rx_sq;
            if (is_positive)
            begin
                decision4 += 4 * (rx_sq - slope_y);
            end
            else
            begin
                cur_x += 1;
                slope_x += 2 * ry_sq;
                decision4 += 4 * (slope_x - slope_y + rx_sq);
            end
        end
        else
        begin
            trace_phase = TRACE_IDLE;
        end
        pt.last_point = (trace_phase == TRACE_IDLE);
        return 1'b1;
    endfunction

    // Sends one command item in bursts separated by random gaps.
    task automatic send_command(input logic cmd, input logic [RADIUS_BITS-1:0] rx,
                                input logic [RADIUS_BITS-1:0] ry);
        point_t pt;
        int     gap;
        if (burst_left == 0)
        begin
            cmd_if.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 30);
        end
        burst_left--;
        cmd_if.valid <= 1'b1;
        cmd_if.cmd <= cmd;
        cmd_if.radius_x <= rx;
        cmd_if.radius_y <= ry;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        items_counted++;
        if (cmd == mepg_pkg::CMD_START && trace_phase != TRACE_IDLE)
        begin
            ellipses_abandoned++;
        end
        if (cmd == mepg_pkg::CMD_START)
        begin
            starts_sent++;
        end
        if (trace_point(cmd, rx, ry, pt))
        begin
            pending_points.push_back(pt);
        end
    endtask

    // Requests the next point; the radius lines carry noise.
    task automatic send_next();
        send_command(mepg_pkg::CMD_NEXT, RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
    endtask

    // Drops valid and waits until every expected point has come back.
    task automatic wait_points_drained();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (pending_points.size() != 0);
    endtask

    // Ends any running ellipse and lets the block go quiet.
    task automatic settle_for_config();
        if (trace_phase != TRACE_IDLE)
        begin
            send_command(mepg_pkg::CMD_START, '0, '0);
            send_next();
        end
        wait_points_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both center registers on back-to-back cycles.
    task automatic write_center(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy);
        settle_for_config();
        write_enable <= 1'b1;
        reg_index <= mepg_pkg::REG_CENTER_X;
        write_data <= cx;
        @(posedge clk);
        center_x_shadow = cx;
        reg_index <= mepg_pkg::REG_CENTER_Y;
        write_data <= cy;
        @(posedge clk);
        center_y_shadow = cy;
        write_enable <= 1'b0;
        center_settings++;
    endtask

    // Random ellipses: mostly complete small runs, some abandoned, some stray requests.
    task automatic run_random_ellipses(input int budget);
        int first;
        int pick;
        int limit;
        int sent;
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;
        first = items_counted;
        while (items_counted - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                rx = RADIUS_BITS'($urandom_range(0, 24));
                ry = RADIUS_BITS'($urandom_range(0, 24));
                limit = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 100000;
            end
            else if (pick < 85)
            begin
                rx = RADIUS_BITS'($urandom_range(25, 60));
                ry = RADIUS_BITS'($urandom_range(0, 60));
                limit = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 100000;
            end
            else
            begin
                rx = RADIUS_BITS'($urandom);
                ry = RADIUS_BITS'($urandom);
                limit = $urandom_range(3, 30);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                {rx, ry} = {ry, rx};
            end

            // A stray request with nothing running.
            if (trace_phase == TRACE_IDLE && $urandom_range(0, 19) == 0)
            begin
                send_next();
            end
            send_command(mepg_pkg::CMD_START, rx, ry);
            sent = 0;
            while (trace_phase != TRACE_IDLE && sent < limit)
            begin
                send_next();
                sent++;
            end
            if (trace_phase == TRACE_IDLE && $urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 2)) send_next();
            end

            // Now and then let the pipeline run dry before going on.
            if ($urandom_range(0, 11) == 0)
            begin
                wait_points_drained();
            end
        end
    endtask

    // Requests with nothing running, zero radii and the vertical run.
    task automatic test_idle_next_and_zero_radii();
        send_next();
        send_command(mepg_pkg::CMD_START, '0, '0);
        send_next();
        send_next();
        send_command(mepg_pkg::CMD_START, 10'd5, '0);
        send_next();
        send_command(mepg_pkg::CMD_START, '0, 10'd3);
        repeat (5) send_next();
    endtask

    // Full-width radii abandoned part way, then a small ellipse across both regions.
    task automatic test_full_radius_abandon();
        send_command(mepg_pkg::CMD_START, 10'd1023, 10'd1023);
        repeat (3) send_next();
        send_command(mepg_pkg::CMD_START, 10'h2AA, 10'h155);
        repeat (2) send_next();
        send_command(mepg_pkg::CMD_START, 10'h155, 10'h2AA);
        send_next();
        send_command(mepg_pkg::CMD_START, 10'd3, 10'd2);
        while (trace_phase != TRACE_IDLE)
        begin
            send_next();
        end
    endtask

    // Centers at the corners of the screen range, so the outputs reach both extremes.
    task automatic test_center_extremes();
        write_center('0, '0);
        run_random_ellipses(150);
        write_center(10'd1023, 10'd1023);
        run_random_ellipses(150);
        write_center('0, 10'd1023);
        run_random_ellipses(150);
        write_center(10'd1023, '0);
        run_random_ellipses(150);
    endtask

    // Long random stretch under random centers.
    task automatic test_random_ellipses();
        repeat (3)
        begin
            write_center(COORD_BITS'($urandom), COORD_BITS'($urandom));
            run_random_ellipses(280);
        end
    endtask

    // Compares one field of a point.
    task automatic check_field(input string name, input logic signed [POINT_BITS-1:0] expected,
                               input logic signed [POINT_BITS-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            errors++;
        end
    endtask

    // Checks each accepted point against the oldest expectation.
    always @(posedge clk)
    begin
        point_t exp_pt;
        if (rst_n && pt_if.valid && pt_if.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("point (%0d, %0d, %0d, %0d) with nothing expected",
                       pt_if.x_right, pt_if.x_left, pt_if.y_below, pt_if.y_above);
                errors++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                check_field("x_right", exp_pt.x_right, pt_if.x_right);
                check_field("x_left", exp_pt.x_left, pt_if.x_left);
                check_field("y_below", exp_pt.y_below, pt_if.y_below);
                check_field("y_above", exp_pt.y_above, pt_if.y_above);
                check_field("last_point", POINT_BITS'(exp_pt.last_point),
                            POINT_BITS'(pt_if.last_point));
                points_checked++;
            end
        end
    end

    // Receiver stalls: free running, random, periodic or long holds.
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: pt_if.ready <= 1'b1;
            1: pt_if.ready <= ($urandom_range(0, 3) != 0);
            2: pt_if.ready <= ((cycle_count % 7) > 2);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    pt_if.ready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_hold = $urandom_range(1, 16);
                    end
                    pt_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n <= 1'b0;
        write_enable <= 1'b0;
        reg_index <= mepg_pkg::REG_CENTER_X;
        write_data <= '0;
        cmd_if.valid <= 1'b0;
        cmd_if.cmd <= mepg_pkg::CMD_START;
        cmd_if.radius_x <= '0;
        cmd_if.radius_y <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_idle_next_and_zero_radii();
        test_full_radius_abandon();
        test_center_extremes();
        test_random_ellipses();

        wait_points_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_points.size() != 0)
        begin
            $error("%0d points never arrived", pending_points.size());
            errors++;
        end

        $display("Sent %0d command items (%0d starts, %0d ellipses cut short), checked %0d points.",
                 items_counted, starts_sent, ellipses_abandoned, points_checked);
        $display("Used %0d center settings, the four screen corners among them.", center_settings);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
